// ===== rtl/dca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dca_pkg: shared types and constants of the captive-portal DNS responder
// Payload structs, verdict codes, register indexes and answer record length.
// ----------------------------------------------------------------------------
package dca_pkg;

	// Default packet size limit in bytes.
	localparam int MAX_PACKET_DEF = 512;

	// Register reset values.
	localparam logic [31:0] IPV4_RESET = 32'd17082560;
	localparam logic [31:0] TTL_RESET  = 32'd10;

	// Configuration register indexes.
	localparam logic CFG_IPV4 = 1'b0;
	localparam logic CFG_TTL  = 1'b1;

	// Verdict codes carried with the final byte of a reply.
	localparam logic [2:0] V_SEND    = 3'd0;
	localparam logic [2:0] V_SHORT   = 3'd1;
	localparam logic [2:0] V_LONG    = 3'd2;
	localparam logic [2:0] V_RECORDS = 3'd3;
	localparam logic [2:0] V_TRUNC   = 3'd4;
	localparam logic [2:0] V_CUT     = 3'd5;
	localparam logic [2:0] V_NOTA    = 3'd6;

	// Answer record: sixteen bytes appended after a valid A query.
	localparam int ANS_LEN   = 16;
	localparam int ANS_IDX_W = $clog2(ANS_LEN);

	// Input transaction payload.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_t;

	// Output transaction payload.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic [2:0] verdict;
	} out_t;

	// Parser result for the byte at its input.
	typedef struct packed {
		out_t res;
		logic answer;
	} parse_t;

	// Answer generator status.
	typedef struct packed {
		logic active;
		logic last_slot;
	} ans_status_t;

endpackage
`default_nettype wire

// ===== rtl/dca_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dca_parser: header rewrite and question walk
// Rewrites header bytes, walks the labels of the first question, captures
// QTYPE and decides the verdict on the final byte of each packet.
// ----------------------------------------------------------------------------
module dca_parser #(
	parameter int MaxPacket = dca_pkg::MAX_PACKET_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire dca_pkg::in_t  in_data,
	output dca_pkg::parse_t    result
);
	import dca_pkg::*;

	localparam int POS_W = $clog2(MaxPacket + 2);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_BODY,
		PH_KHI,
		PH_KLO,
		PH_DONE
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0] label_q, label_n;
	logic [15:0] kind_q, kind_n;
	logic       kind_done_q, kind_done_n;
	logic       records_q, records_n;
	logic       trunc_q, trunc_n;
	logic [7:0] ob;
	logic [2:0] verdict;
	logic       in_header;

	// Next state and output byte for the byte at the input.
	always_comb begin
		phase_n     = phase_q;
		label_n     = label_q;
		kind_n      = kind_q;
		kind_done_n = kind_done_q;
		records_n   = records_q;
		trunc_n     = trunc_q;
		ob          = in_data.in_byte;
		in_header   = pos_q < POS_W'(12);

		if (in_header) begin
			if (pos_q == POS_W'(2)) begin
				trunc_n = trunc_q | in_data.in_byte[1];
				ob      = in_data.in_byte | 8'h80;
			end else if (pos_q == POS_W'(3)) begin
				ob = in_data.in_byte | 8'h80;
			end
			if (pos_q >= POS_W'(6) && in_data.in_byte != 8'h00) begin
				records_n = 1'b1;
			end
			if (pos_q == POS_W'(6)) ob = 8'h00;
			if (pos_q == POS_W'(7)) ob = 8'h01;
			if (pos_q == POS_W'(11)) phase_n = PH_LEN;
		end else begin
			case (phase_q)
				PH_LEN: begin
					if (in_data.in_byte == 8'h00) begin
						phase_n = PH_KHI;
					end else begin
						label_n = in_data.in_byte;
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					label_n = label_q - 8'd1;
					if (label_n == 8'h00) phase_n = PH_LEN;
				end
				PH_KHI: begin
					kind_n  = {in_data.in_byte, 8'h00};
					phase_n = PH_KLO;
				end
				PH_KLO: begin
					kind_n      = {kind_q[15:8], in_data.in_byte};
					kind_done_n = 1'b1;
					phase_n     = PH_DONE;
				end
				default: begin
				end
			endcase
		end

		// Byte position saturates one past the limit.
		pos_n = (pos_q <= POS_W'(MaxPacket)) ? pos_q + POS_W'(1) : pos_q;

		// Verdict in priority order, using this byte's updates.
		if (pos_q >= POS_W'(MaxPacket))  verdict = V_LONG;
		else if (pos_q < POS_W'(11))     verdict = V_SHORT;
		else if (records_n)              verdict = V_RECORDS;
		else if (trunc_n)                verdict = V_TRUNC;
		else if (!kind_done_n)           verdict = V_CUT;
		else if (kind_n != 16'h0001)     verdict = V_NOTA;
		else                             verdict = V_SEND;

		// The final byte returns all packet state to its reset value.
		if (in_data.last_byte) begin
			phase_n     = PH_HEADER;
			pos_n       = '0;
			label_n     = '0;
			kind_n      = '0;
			kind_done_n = 1'b0;
			records_n   = 1'b0;
			trunc_n     = 1'b0;
		end
	end

	// Result for this byte; a sent reply ends with the answer record.
	always_comb begin
		result.res.out_byte = ob;
		result.res.out_last = in_data.last_byte && (verdict != V_SEND);
		result.res.verdict  = in_data.last_byte ? verdict : V_SEND;
		result.answer       = in_data.last_byte && (verdict == V_SEND);
	end

	// Packet state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			label_q     <= '0;
			kind_q      <= '0;
			kind_done_q <= 1'b0;
			records_q   <= 1'b0;
			trunc_q     <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			label_q     <= label_n;
			kind_q      <= kind_n;
			kind_done_q <= kind_done_n;
			records_q   <= records_n;
			trunc_q     <= trunc_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dca_answer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dca_answer: answer record generator
// Steps through the sixteen bytes of the A record once started.
// ----------------------------------------------------------------------------
module dca_answer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        advance,
	input  wire logic [31:0] ipv4,
	input  wire logic [31:0] ttl,
	output dca_pkg::out_t    ans_byte,
	output dca_pkg::ans_status_t status
);
	import dca_pkg::*;

	localparam logic [ANS_IDX_W-1:0] LAST_IDX = ANS_IDX_W'(ANS_LEN - 1);

	logic [ANS_IDX_W-1:0] idx_q;
	logic                 active_q;
	logic [7:0]           b;

	// Record layout: pointer, type, class, TTL, length, address low first.
	always_comb begin
		case (idx_q)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h00;
			4'd5:    b = 8'h01;
			4'd6:    b = ttl[31:24];
			4'd7:    b = ttl[23:16];
			4'd8:    b = ttl[15:8];
			4'd9:    b = ttl[7:0];
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h04;
			4'd12:   b = ipv4[7:0];
			4'd13:   b = ipv4[15:8];
			4'd14:   b = ipv4[23:16];
			default: b = ipv4[31:24];
		endcase
	end

	assign ans_byte.out_byte = b;
	assign ans_byte.out_last = (idx_q == LAST_IDX);
	assign ans_byte.verdict  = V_SEND;
	assign status.active     = active_q;
	assign status.last_slot  = (idx_q == LAST_IDX);

	// Byte counter of the record being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (advance && active_q) begin
			if (idx_q == LAST_IDX) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + ANS_IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dns_captive_a_responder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dns_captive_a_responder: captive-portal DNS responder for A queries
// Echoes a DNS query byte by byte as a reply; valid A queries get an A record.
// ----------------------------------------------------------------------------
// Usage:
//   Query bytes enter on the in_* valid/ready channel, one per transaction,
//   with last_byte marking the end of the packet. Each byte leaves on the
//   out_* channel the cycle after it is accepted, with the header rewritten.
//   Throughput is one byte per cycle, set by the single output register,
//   while out_ready is high and no answer record drains. When the final byte
//   completes a valid A query, sixteen answer bytes follow while in_ready
//   is low, one per cycle with out_ready high. The final transaction of every
//   reply carries out_last and a verdict: send, or a reason to drop it.
//   When the receiver stalls, the output register holds its transaction and
//   in_ready falls in the same cycle; nothing is lost.
//   Registers ap_ipv4_address (index 0) and answer_ttl (index 1) are set via
//   cfg_we/cfg_index/cfg_data; the user must write them only while no packet
//   is in flight; the block does not enforce it. Reset clears the parser to
//   the header phase, empties the output register and loads register defaults.
// ----------------------------------------------------------------------------
module dns_captive_a_responder #(
	parameter int MAX_PACKET = dca_pkg::MAX_PACKET_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire dca_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output dca_pkg::out_t     out_data,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import dca_pkg::*;

	logic        ipv4_q;
	logic [31:0] ipv4_reg_q;
	logic [31:0] ttl_q;
	logic        load;
	logic        in_acc;
	logic        ans_adv;
	parse_t      parse;
	out_t        ans_byte;
	ans_status_t ans_st;
	logic        out_valid_q;
	out_t        out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv4_reg_q <= IPV4_RESET;
			ttl_q      <= TTL_RESET;
			ipv4_q     <= 1'b0;
		end else begin
			ipv4_q <= 1'b0;
			if (cfg_we && cfg_index == CFG_IPV4) ipv4_reg_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_TTL)  ttl_q      <= cfg_data;
		end
	end

	// Handshake: the output register takes a new transaction when it empties.
	assign load     = !out_valid_q || out_ready;
	assign in_ready = load && !ans_st.active && !ipv4_q;
	assign in_acc   = in_valid && in_ready;
	assign ans_adv  = load && ans_st.active;

	dca_parser #(
		.MaxPacket(MAX_PACKET)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_acc),
		.in_data(in_data),
		.result (parse)
	);

	dca_answer u_answer (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && parse.answer),
		.advance (ans_adv),
		.ipv4    (ipv4_reg_q),
		.ttl     (ttl_q),
		.ans_byte(ans_byte),
		.status  (ans_st)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc || ans_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= parse.res;
		end else if (ans_adv) begin
			out_q <= ans_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A query that earns an answer starts the record drain.
	a_ans_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && parse.answer |=> ans_st.active)
		else $error("answer record did not start after a valid A query");

	// A drop verdict only travels on the final transaction.
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.verdict != V_SEND |-> out_q.out_last)
		else $error("drop verdict on a transaction that is not the last");

	// The drain ends after its last slot is loaded.
	a_ans_end: assert property (@(posedge clk) disable iff (!arst_n)
		ans_adv && ans_st.last_slot |=> !ans_st.active)
		else $error("answer drain ran past its last byte");

	// While a record drains, the output register holds a transaction.
	a_ans_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ans_st.active |-> out_valid_q)
		else $error("output register empty during answer drain");

endmodule
`default_nettype wire

// ===== bench/dns_captive_a_responder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_captive_a_responder_tb: self-checking bench for the DNS A responder
// Streams DNS queries through the block under random gaps on both channels.
// Each query byte accepted is run through a local model of the parser. The
// model queues the reply bytes and the verdict that the block must return.
// ----------------------------------------------------------------------------
module dns_captive_a_responder_tb;
	import dca_pkg::*;

	localparam int PKT_LIMIT   = MAX_PACKET_DEF;
	localparam int CYCLE_LIMIT = 500000;

	// Parser walk through the first question.
	typedef enum logic [2:0] {W_HDR, W_LEN, W_BODY, W_KHI, W_KLO, W_DONE} walk_t;

	// Shapes of generated packets.
	typedef enum int {
		PK_GOOD, PK_OTHER_TYPE, PK_RECORDS, PK_TC, PK_CUT, PK_NOISE, PK_ODD_LABEL
	} pkt_kind_t;

	// One row of the directed table; want is checked only when known is set.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       known;
		out_t       want;
	} probe_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	// Model state: registers and the per-packet parser.
	logic [31:0] ap_addr;
	logic [31:0] ans_ttl;
	int          pkt_pos;
	walk_t       walk;
	logic [7:0]  skip_left;
	logic [15:0] qkind;
	logic        kind_done;
	logic        rr_seen;
	logic        tc_seen;

	out_t        expected_reply [$];
	logic [7:0]  pkt_bytes [$];
	int          mismatches;
	int          reply_count;
	int          cycle_count;
	int          phase_items;
	bit          in_calm;
	bit          rx_calm;

	// Single-byte short packet, a minimal A query, then a three-byte short one.
	probe_row_t dir_rows [19] = '{
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, V_SHORT}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b1, '{8'h80, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b1, '{8'h80, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b1, '{8'h01, 1'b0, V_SEND}},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b1, 1'b0, '0},
		'{8'h12, 1'b0, 1'b0, '0},
		'{8'h34, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, V_SHORT}}
	};

	dns_captive_a_responder #(
		.MAX_PACKET(PKT_LIMIT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Free-running cycle count for the watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Clears the per-packet parser state.
	function automatic void clear_walk();
		pkt_pos   = 0;
		walk      = W_HDR;
		skip_left = 8'd0;
		qkind     = 16'd0;
		kind_done = 1'b0;
		rr_seen   = 1'b0;
		tc_seen   = 1'b0;
	endfunction

	// Updates the parser with one query byte and queues the reply bytes that
	// it causes. Returns how many were queued.
	function automatic int predict_reply(in_t t);
		int         pos;
		logic [7:0] ob;
		logic [2:0] v;
		logic [7:0] rec [16];

		pos = pkt_pos;
		ob  = t.in_byte;
		if (pos < 12) begin
			// Header: set QR and RA, force the answer count to one.
			if (pos == 2) begin
				if (t.in_byte[1]) tc_seen = 1'b1;
				ob = t.in_byte | 8'h80;
			end else if (pos == 3) begin
				ob = t.in_byte | 8'h80;
			end
			if (pos >= 6 && t.in_byte != 8'd0) rr_seen = 1'b1;
			if (pos == 6) ob = 8'h00;
			if (pos == 7) ob = 8'h01;
			if (pos == 11) walk = W_LEN;
		end else begin
			// Question: skip labels, then capture QTYPE.
			case (walk)
				W_LEN: begin
					if (t.in_byte == 8'd0) begin
						walk = W_KHI;
					end else begin
						skip_left = t.in_byte;
						walk      = W_BODY;
					end
				end
				W_BODY: begin
					skip_left = skip_left - 8'd1;
					if (skip_left == 8'd0) walk = W_LEN;
				end
				W_KHI: begin
					qkind = {t.in_byte, 8'h00};
					walk  = W_KLO;
				end
				W_KLO: begin
					qkind[7:0] = t.in_byte;
					kind_done  = 1'b1;
					walk       = W_DONE;
				end
				default: ;
			endcase
		end
		if (pkt_pos <= PKT_LIMIT) pkt_pos++;

		if (!t.last_byte) begin
			expected_reply.push_back('{ob, 1'b0, V_SEND});
			return 1;
		end

		// Verdict priority: long, short, records, truncated, cut, not A.
		if (pos >= PKT_LIMIT) v = V_LONG;
		else if (pos < 11) v = V_SHORT;
		else if (rr_seen) v = V_RECORDS;
		else if (tc_seen) v = V_TRUNC;
		else if (!kind_done) v = V_CUT;
		else if (qkind != 16'd1) v = V_NOTA;
		else v = V_SEND;
		clear_walk();

		if (v != V_SEND) begin
			expected_reply.push_back('{ob, 1'b1, v});
			return 1;
		end

		// Answer record: pointer, type A, class IN, TTL, length 4, address.
		rec = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
			ans_ttl[31:24], ans_ttl[23:16], ans_ttl[15:8], ans_ttl[7:0],
			8'h00, 8'h04,
			ap_addr[7:0], ap_addr[15:8], ap_addr[23:16], ap_addr[31:24]};
		expected_reply.push_back('{ob, 1'b0, V_SEND});
		for (int i = 0; i < 16; i++) begin
			expected_reply.push_back('{rec[i], (i == 15), V_SEND});
		end
		return 17;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(string field, int want_v, int got_v);
		$display("reply byte %0d: %s expected 0x%0h, got 0x%0h at %0t ns",
			reply_count, field, want_v, got_v, $time);
		mismatches++;
	endtask

	// Compares every accepted reply transaction with the oldest expectation.
	always @(posedge clk) begin : reply_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reply.size() == 0) begin
				report_mismatch("unexpected transaction, out_byte", 0,
					int'(out_data.out_byte));
			end else begin
				want = expected_reply.pop_front();
				if (out_data.out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(want.out_byte),
						int'(out_data.out_byte));
				if (out_data.out_last !== want.out_last)
					report_mismatch("out_last", int'(want.out_last),
						int'(out_data.out_last));
				if (out_data.verdict !== want.verdict)
					report_mismatch("verdict", int'(want.verdict),
						int'(out_data.verdict));
			end
			reply_count++;
		end
	end

	// Receiver: a random stall before each reply transaction, with calm runs.
	initial begin : reply_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
			if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
		end
	end

	// Drives one query byte and updates the model when it is accepted.
	// Called and returning at a falling edge.
	task automatic send_item(logic [7:0] b, logic last, logic known, out_t want);
		int gap;
		int n;
		gap = in_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{b, last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n = predict_reply('{b, last});
		if (known) expected_reply[expected_reply.size() - n] = want;
		phase_items++;
		@(negedge clk);
	endtask

	// Builds one packet of the given kind into pkt_bytes. For a cut packet a
	// nonzero size sets the length; other kinds but noise are padded to it.
	task automatic build_packet(pkt_kind_t kind, int size);
		logic [7:0] flags;
		int         nlab;
		int         len;
		int         rr_pos;
		pkt_bytes.delete();
		if (kind == PK_NOISE) begin
			len = $urandom_range(1, 24);
			repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		// Header: ID, flags, QDCOUNT, then zero counts unless records are wanted.
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		flags = 8'($urandom_range(0, 255));
		if (kind == PK_TC) flags[1] = 1'b1;
		else if (kind == PK_GOOD || kind == PK_ODD_LABEL) flags[1] = 1'b0;
		pkt_bytes.push_back(flags);
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		pkt_bytes.push_back(8'($urandom_range(0, 255)));
		rr_pos = (kind == PK_RECORDS) ? $urandom_range(6, 11) : -1;
		for (int p = 6; p < 12; p++) begin
			pkt_bytes.push_back(8'((p == rr_pos) ? $urandom_range(1, 255) : 0));
		end
		// Name: a few short labels, or one label with a pointer-like length.
		if (kind == PK_ODD_LABEL) begin
			len = $urandom_range(192, 255);
			pkt_bytes.push_back(8'(len));
			repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			nlab = $urandom_range(0, 3);
			repeat (nlab) begin
				len = $urandom_range(1, 6);
				pkt_bytes.push_back(8'(len));
				repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		pkt_bytes.push_back(8'h00);
		// QTYPE, QCLASS and a few trailing bytes.
		if (kind == PK_OTHER_TYPE) begin
			pkt_bytes.push_back(8'($urandom_range(0, 255)));
			pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			pkt_bytes.push_back(8'h00);
			pkt_bytes.push_back(8'h01);
		end
		pkt_bytes.push_back(8'h00);
		pkt_bytes.push_back(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 1));
		repeat ($urandom_range(0, 2)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		if (kind == PK_CUT) begin
			len = (size > 0) ? size : $urandom_range(1, pkt_bytes.size() - 1);
			while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
		end else begin
			while (pkt_bytes.size() < size)
				pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Sends pkt_bytes as one packet, with the last byte marked.
	task automatic send_packet();
		in_calm = ($urandom_range(0, 4) == 0);
		foreach (pkt_bytes[i]) begin
			send_item(pkt_bytes[i], (i == pkt_bytes.size() - 1), 1'b0, '0);
		end
	endtask

	// Waits until every expected reply has left and the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_reply.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IPV4) ap_addr = val;
		else ans_ttl = val;
	endtask

	// Picks a random packet shape, weighted toward well-formed A queries.
	function automatic pkt_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 15);
		if (r <= 6) return PK_GOOD;
		if (r <= 8) return PK_OTHER_TYPE;
		if (r == 9) return PK_RECORDS;
		if (r == 10) return PK_TC;
		if (r <= 12) return PK_CUT;
		return PK_NOISE;
	endfunction

	// Watchdog.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("[dns_captive_a_responder] ERROR");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, long packets.
	initial begin : main_seq
		logic [31:0] set_addr [5];
		logic [31:0] set_ttl [5];
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_IPV4;
		cfg_data    = 32'd0;
		mismatches  = 0;
		reply_count = 0;
		cycle_count = 0;
		in_calm     = 1'b0;
		rx_calm     = 1'b0;
		ap_addr     = IPV4_RESET;
		ans_ttl     = TTL_RESET;
		clear_walk();
		set_addr = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};
		set_ttl  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, $urandom};

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part runs with the register reset values.
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].known, dir_rows[i].want);
		end
		settle();

		// Random packets under several register settings, extremes first.
		for (int s = 0; s < 5; s++) begin
			write_reg(CFG_IPV4, set_addr[s]);
			write_reg(CFG_TTL, set_ttl[s]);
			phase_items = 0;
			while (phase_items < 70) begin
				build_packet(pick_kind(), 0);
				send_packet();
			end
			settle();
		end

		// Length boundaries and a pointer-like label length.
		write_reg(CFG_IPV4, $urandom);
		write_reg(CFG_TTL, $urandom);
		build_packet(PK_CUT, 11);
		send_packet();
		build_packet(PK_CUT, 12);
		send_packet();
		build_packet(PK_ODD_LABEL, 0);
		send_packet();
		build_packet(PK_GOOD, PKT_LIMIT);
		send_packet();
		build_packet(PK_RECORDS, PKT_LIMIT + 1);
		send_packet();
		build_packet(PK_GOOD, 0);
		send_packet();
		settle();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_reply.size() == 0)
			$display("[dns_captive_a_responder] OK");
		else
			$display("[dns_captive_a_responder] ERROR");
		$finish;
	end

endmodule

// ===== dns_captive_a_responder.f =====
rtl/dca_pkg.sv
rtl/dca_parser.sv
rtl/dca_answer.sv
rtl/dns_captive_a_responder.sv
bench/dns_captive_a_responder_tb.sv
